// ===== hw/rtl/rpwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpwc_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int CHAN_W     = 3;
    localparam int TIME_W     = 16;
    localparam int CFG_ADDR_W = 2;

    // stream packing: tdata padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_CAPTURE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OVERFLOW = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WIDTH = 2'd1;

    localparam logic [TIME_W-1:0] WIDTH_MAX = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // latch the incoming transaction
        logic exec;      // apply the latched request
    } rpwc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_read;      // latched request produces a result
        logic out_blocked;  // result register full and not drained this cycle
    } rpwc_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc_pulse_width_capture.sv =====
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid/s_tready    s_tdata: channel, capture_time; s_tuser: req_type
//  m_       out  m_tvalid/m_tready    m_tdata: read_channel, pulse_width; m_tuser: width_valid
//  cfg_     in   cfg_valid/cfg_ready  cfg_addr: register index; cfg_data: value
//
//  Each request is latched in the IDLE state and then applied by the datapath in the
//  EXEC state (a single subtract-and-compare against the channel table).
//  A read result lands in an output register; the next request is taken while
//  it waits. A read that meets a full, undrained output register holds in the
//  execute cycle until m_tready frees it. cfg_ready is always high.
//  aresetn is synchronous, active low; it clears every channel and resets the bounds.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_width_capture #(
    parameter int CHANNELS = 8   // channels in the table, 1..8
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // request stream
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    input  wire  [rpwc_pkg::S_TDATA_W-1:0]         s_tdata,  // [2:0] channel, [18:3] capture_time
    input  wire  [rpwc_pkg::S_TUSER_W-1:0]         s_tuser,  // [1:0] req_type
    // result stream
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    output logic [rpwc_pkg::M_TDATA_W-1:0]         m_tdata,  // [2:0] read_channel, [18:3] pulse_width
    output logic [rpwc_pkg::M_TUSER_W-1:0]         m_tuser,  // [0] width_valid
    // configuration writes
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [rpwc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire  [rpwc_pkg::TIME_W-1:0]            cfg_data
);
    import rpwc_pkg::*;

    rpwc_cmd_t         cmd;
    rpwc_sts_t         sts;
    logic [CHAN_W-1:0] out_chan;
    logic [TIME_W-1:0] out_width;
    logic              out_flag;

    // config registers are plain writes, never stalled
    assign cfg_ready = 1'b1;

    rpwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpwc_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (s_tuser[REQ_W-1:0]),
        .in_chan   (s_tdata[CHAN_W-1:0]),
        .in_time   (s_tdata[CHAN_W+TIME_W-1:CHAN_W]),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_chan  (out_chan),
        .out_width (out_width),
        .out_flag  (out_flag)
    );

    // pack result, pad upper bits with zeros
    assign m_tdata = {{(M_TDATA_W-CHAN_W-TIME_W){1'b0}}, out_width, out_chan};
    assign m_tuser = out_flag;

endmodule

`default_nettype wire

// ===== hw/rtl/rpwc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpwc_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  rpwc_pkg::rpwc_sts_t   sts,
    output rpwc_pkg::rpwc_cmd_t   cmd
);
    import rpwc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a read waits until the result register can take it
                if (!(sts.is_read && sts.out_blocked)) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rpwc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpwc_datapath #(
    parameter int CHANNELS = 8
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  rpwc_pkg::rpwc_cmd_t                   cmd,
    output rpwc_pkg::rpwc_sts_t                   sts,
    input  wire  [rpwc_pkg::REQ_W-1:0]            in_req,
    input  wire  [rpwc_pkg::CHAN_W-1:0]           in_chan,
    input  wire  [rpwc_pkg::TIME_W-1:0]           in_time,
    input  wire                                   cfg_valid,
    input  wire  [rpwc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire  [rpwc_pkg::TIME_W-1:0]           cfg_data,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [rpwc_pkg::CHAN_W-1:0]           out_chan,
    output logic [rpwc_pkg::TIME_W-1:0]           out_width,
    output logic                                  out_flag
);
    import rpwc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // latched request
    logic [REQ_W-1:0]  req_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [TIME_W-1:0] time_reg;

    // configuration
    logic [TIME_W-1:0] min_width_reg;
    logic [TIME_W-1:0] max_width_reg;

    // per-channel state
    logic [TIME_W-1:0] last_stamp_reg [CHANNELS];
    logic [TIME_W-1:0] last_stamp_next[CHANNELS];
    logic [TIME_W-1:0] held_width_reg [CHANNELS];
    logic [TIME_W-1:0] held_width_next[CHANNELS];
    logic [CHANNELS-1:0] fresh_reg;
    logic [CHANNELS-1:0] fresh_next;
    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] valid_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [TIME_W-1:0] out_width_reg;
    logic              out_flag_reg;

    logic [IDX_W+CHAN_W-1:0] chan_wide;
    logic [IDX_W-1:0]        idx;
    logic                    in_range;
    logic [TIME_W-1:0]       diff;
    logic                    diff_ok;
    logic                    load_out;

    assign chan_wide = {{IDX_W{1'b0}}, chan_reg};
    assign idx       = chan_wide[IDX_W-1:0];
    assign in_range  = ({29'd0, chan_reg} < 32'(CHANNELS));
    // modulo-2^16 distance from the previous edge
    assign diff      = time_reg - last_stamp_reg[idx];
    assign diff_ok   = (diff > min_width_reg) && (diff < max_width_reg);

    assign sts.is_read     = (req_reg == REQ_READ);
    assign sts.out_blocked = out_valid_reg && !out_ready;

    assign load_out = cmd.exec && (req_reg == REQ_READ);

    always_comb begin
        last_stamp_next = last_stamp_reg;
        held_width_next = held_width_reg;
        fresh_next      = fresh_reg;
        valid_next      = valid_reg;
        if (cmd.exec) begin
            case (req_reg)
                REQ_CAPTURE: begin
                    if (in_range) begin
                        last_stamp_next[idx] = time_reg;
                        if (diff_ok) begin
                            held_width_next[idx] = diff;
                            fresh_next[idx]      = 1'b1;
                            valid_next[idx]      = 1'b1;
                        end
                    end
                end
                REQ_OVERFLOW: begin
                    // fresh -> stale, stale -> invalid
                    valid_next = valid_reg & fresh_reg;
                    fresh_next = '0;
                end
                REQ_CLEAR: begin
                    if (in_range) begin
                        last_stamp_next[idx] = '0;
                        held_width_next[idx] = '0;
                        fresh_next[idx]      = 1'b0;
                        valid_next[idx]      = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                last_stamp_reg[i] <= '0;
                held_width_reg[i] <= '0;
            end
            fresh_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            min_width_reg <= '0;
            max_width_reg <= WIDTH_MAX;
        end else begin
            last_stamp_reg <= last_stamp_next;
            held_width_reg <= held_width_next;
            fresh_reg      <= fresh_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_MIN_WIDTH: min_width_reg <= cfg_data;
                    CFG_MAX_WIDTH: max_width_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg  <= in_req;
            chan_reg <= in_chan;
            time_reg <= in_time;
        end
        if (load_out) begin
            out_chan_reg <= chan_reg;
            if (in_range && valid_reg[idx]) begin
                out_width_reg <= held_width_reg[idx];
                out_flag_reg  <= 1'b1;
            end else begin
                out_width_reg <= '0;
                out_flag_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_chan  = out_chan_reg;
    assign out_width = out_width_reg;
    assign out_flag  = out_flag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rpwc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpwc_checker (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_tvalid,
    input wire                                 s_tready,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire [rpwc_pkg::M_TDATA_W-1:0]       m_tdata,
    input wire [rpwc_pkg::M_TUSER_W-1:0]       m_tuser
);
    import rpwc_pkg::*;

    // stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // an invalid channel reads as zero width
    a_zero_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[CHAN_W+TIME_W-1:CHAN_W] == '0)
        else $error("invalid channel reported nonzero width");

    // a request is executed before the next one is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous still executing");

endmodule

bind rc_pulse_width_capture rpwc_checker u_rpwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
